>>> rtl/reconnect_backoff_jitter_macros.svh
// Assertion macros for the reconnect backoff scheduler.
// Included by rbj_jitter and reconnect_backoff_jitter; define ASSERT_OFF to drop the checks.
`ifndef RECONNECT_BACKOFF_JITTER_MACROS_SVH
`define RECONNECT_BACKOFF_JITTER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define RBJ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbj: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define RBJ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbj: next-cycle check failed");
`else
`define RBJ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RBJ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/rbj_pkg.sv
// Shared widths, reset values and codes for the reconnect backoff scheduler.
// No dependencies; imported by rbj_jitter and reconnect_backoff_jitter.
`timescale 1ns / 1ps

package rbj_pkg;

    localparam int TIME_W    = 32;              // millisecond time
    localparam int BO_W      = 20;              // backoff and config registers
    localparam int RND_W     = 31;              // random word
    localparam int R_W       = BO_W - 2;        // backoff / 5 always fits here
    localparam int SPAN_W    = R_W + 1;         // 2r + 1
    localparam int JIT_W     = BO_W + 1;        // jittered backoff
    localparam int DIV_STEPS = BO_W / 2;        // radix-4 digits of the backoff
    localparam int CNT_W     = $clog2(RND_W);   // step counter of the serial unit

    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 64;             // now_ms, link_up, random_word
    localparam int OUT_DATA_W = 56;             // three flags, next_due, backoff

    localparam logic [BO_W-1:0] INIT_BACKOFF_RST = BO_W'(1000);
    localparam logic [BO_W-1:0] MAX_BACKOFF_RST  = BO_W'(30000);

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_BACKOFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BACKOFF  = 2'd1;

    // Item kinds carried on tuser
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_BEGIN = 1'b1;

endpackage

>>> rtl/rbj_jitter.sv
// Serial jitter unit: r = backoff / 5 by radix-4 long division, then
// random_word mod (2r + 1) one bit per cycle. Depends on rbj_pkg.
`timescale 1ns / 1ps
`include "reconnect_backoff_jitter_macros.svh"

module rbj_jitter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rbj_pkg::BO_W-1:0]    i_backoff,
    input  logic [rbj_pkg::RND_W-1:0]   i_rnd,
    output logic                        o_done,
    output logic [rbj_pkg::R_W-1:0]     o_r,
    output logic [rbj_pkg::SPAN_W-1:0]  o_mod
);
    import rbj_pkg::*;

    localparam logic [1:0] J_IDLE = 2'd0;
    localparam logic [1:0] J_DIV  = 2'd1;
    localparam logic [1:0] J_MOD  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [BO_W-1:0]   r_bsh, n_bsh;
    logic [R_W-1:0]    r_q, n_q;
    logic [2:0]        r_rem5, n_rem5;
    logic [RND_W-1:0]  r_rsh, n_rsh;
    logic [SPAN_W-1:0] r_span, n_span;
    logic [SPAN_W-1:0] r_rem, n_rem;
    logic              r_done, n_done;

    logic [4:0]        w_v;      // partial remainder with the next base-4 digit
    logic [1:0]        w_qd;
    logic [2:0]        w_rem5;
    logic [SPAN_W:0]   w_t;      // shifted remainder with the next random bit

    // One base-4 quotient digit of the division by five
    always_comb begin
        w_v = {r_rem5, r_bsh[BO_W-1 -: 2]};
        if (w_v >= 5'd15) begin
            w_qd   = 2'd3;
            w_rem5 = 3'(w_v - 5'd15);
        end else if (w_v >= 5'd10) begin
            w_qd   = 2'd2;
            w_rem5 = 3'(w_v - 5'd10);
        end else if (w_v >= 5'd5) begin
            w_qd   = 2'd1;
            w_rem5 = 3'(w_v - 5'd5);
        end else begin
            w_qd   = 2'd0;
            w_rem5 = w_v[2:0];
        end
    end

    assign w_t = {r_rem, r_rsh[RND_W-1]};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bsh   = r_bsh;
        n_q     = r_q;
        n_rem5  = r_rem5;
        n_rsh   = r_rsh;
        n_span  = r_span;
        n_rem   = r_rem;
        n_done  = 1'b0;
        case (r_state)
            J_IDLE: begin
                if (i_start) begin
                    n_state = J_DIV;
                    n_cnt   = CNT_W'(DIV_STEPS - 1);
                    n_bsh   = i_backoff;
                    n_rsh   = i_rnd;
                    n_q     = '0;
                    n_rem5  = '0;
                end
            end
            J_DIV: begin
                // top digit of the quotient is always zero and drops out
                n_q    = {r_q[R_W-3:0], w_qd};
                n_rem5 = w_rem5;
                n_bsh  = {r_bsh[BO_W-3:0], 2'b00};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = J_MOD;
                    n_cnt   = CNT_W'(RND_W - 1);
                    n_span  = {n_q, 1'b1};
                    n_rem   = '0;
                end
            end
            J_MOD: begin
                if (w_t >= {1'b0, r_span}) begin
                    n_rem = SPAN_W'(w_t - {1'b0, r_span});
                end else begin
                    n_rem = w_t[SPAN_W-1:0];
                end
                n_rsh = {r_rsh[RND_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = J_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = J_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= J_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt  <= n_cnt;
        r_bsh  <= n_bsh;
        r_q    <= n_q;
        r_rem5 <= n_rem5;
        r_rsh  <= n_rsh;
        r_span <= n_span;
        r_rem  <= n_rem;
    end

    assign o_done = r_done;
    assign o_r    = r_q;
    assign o_mod  = r_rem;

    `RBJ_ASSERT_IMP(a_rem_below_span, i_clk, i_rst_n, r_state == J_MOD, r_rem < r_span)
    `RBJ_ASSERT_IMP(a_done_from_idle, i_clk, i_rst_n, r_done, r_state == J_IDLE)
    `RBJ_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done)

endmodule

>>> rtl/reconnect_backoff_jitter.sv
// Flow: a start request, a tick with link up or a tick not yet due goes from S_EVAL to S_DONE;
// a due tick waits in S_JIT for rbj_jitter: 10 radix-4 steps of backoff/5 and 31 bit steps of
// random mod (2r+1). One item at a time: the next is accepted only after the result is loaded
// into the output register, so a held result stalls.
// Reset (i_rst_n low, synchronous): backoff 1000 ms, max 30000 ms, next due 0, link seen down.
// Depends on rbj_pkg, rbj_jitter and reconnect_backoff_jitter_macros.svh.
`timescale 1ns / 1ps
`include "reconnect_backoff_jitter_macros.svh"

module reconnect_backoff_jitter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [rbj_pkg::IN_DATA_W-1:0]     i_s_tdata,  // now_ms, link_up, random_word
    input  logic                              i_s_tuser,  // func
    // result items
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // attempt_now, link_came_up, link_went_down, next_due_ms, backoff_now_ms, zero pad
    output logic [rbj_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rbj_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rbj_pkg::BO_W-1:0]          i_cfg_data
);
    import rbj_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;  // take the next item
    localparam logic [1:0] S_EVAL = 2'd1;  // decide what the item does
    localparam logic [1:0] S_JIT  = 2'd2;  // wait for the jitter draw
    localparam logic [1:0] S_DONE = 2'd3;  // hand the result to the output register

    logic [1:0]        r_state, n_state;

    // configuration
    logic [BO_W-1:0]   r_init_backoff;
    logic [BO_W-1:0]   r_max_backoff;

    // scheduler state
    logic              r_was_up, n_was_up;
    logic [TIME_W-1:0] r_next_due, n_next_due;
    logic [BO_W-1:0]   r_backoff, n_backoff;

    // latched item
    logic              r_func;
    logic [TIME_W-1:0] r_now;
    logic              r_up;
    logic [RND_W-1:0]  r_rnd;

    // result flags of the current item
    logic              r_att, n_att;
    logic              r_came, n_came;
    logic              r_went, n_went;

    // output register
    logic                  r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    logic              w_accept;
    logic              w_jit_start;
    logic              w_jit_done;
    logic [R_W-1:0]    w_jit_r;
    logic [SPAN_W-1:0] w_jit_mod;
    logic [JIT_W-1:0]  w_jit;
    logic [JIT_W-1:0]  w_dbl;
    logic [TIME_W-1:0] w_due_ref;
    logic              w_oload;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;

    // Jittered backoff: backoff + (rnd mod (2r+1)) - r, never negative since r <= backoff/5
    assign w_jit = JIT_W'({1'b0, r_backoff} + JIT_W'(w_jit_mod) - JIT_W'(w_jit_r));
    // Doubled backoff, one bit wider so it never wraps
    assign w_dbl = {r_backoff, 1'b0};
    // A drop seen on this tick makes the retry due right away
    assign w_due_ref = r_was_up ? r_now : r_next_due;

    // Load the output register once it is empty or being drained
    assign w_oload = (r_state == S_DONE) && (!r_ovalid || i_m_tready);

    always_comb begin
        n_state     = r_state;
        n_was_up    = r_was_up;
        n_next_due  = r_next_due;
        n_backoff   = r_backoff;
        n_att       = r_att;
        n_came      = r_came;
        n_went      = r_went;
        w_jit_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EVAL;
                    n_att   = 1'b0;
                    n_came  = 1'b0;
                    n_went  = 1'b0;
                end
            end
            S_EVAL: begin
                n_state = S_DONE;
                if (r_func == FUNC_BEGIN) begin
                    // start request: attempt now, next one a plain backoff later
                    n_att      = 1'b1;
                    n_next_due = r_now + TIME_W'(r_backoff);
                end else if (r_up) begin
                    // link up: restore the initial backoff on the rising edge
                    if (!r_was_up) begin
                        n_was_up  = 1'b1;
                        n_backoff = r_init_backoff;
                        n_came    = 1'b1;
                    end
                end else begin
                    // link down: note a falling edge, then test the due time
                    if (r_was_up) begin
                        n_was_up   = 1'b0;
                        n_went     = 1'b1;
                        n_next_due = r_now;
                    end
                    if (r_now >= w_due_ref) begin
                        n_att       = 1'b1;
                        w_jit_start = 1'b1;
                        n_state     = S_JIT;
                    end
                end
            end
            S_JIT: begin
                if (w_jit_done) begin
                    n_next_due = r_now + TIME_W'(w_jit);
                    n_backoff  = (w_dbl > {1'b0, r_max_backoff}) ?
                                 r_max_backoff : w_dbl[BO_W-1:0];
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (w_oload) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_init_backoff <= INIT_BACKOFF_RST;
            r_max_backoff  <= MAX_BACKOFF_RST;
            r_was_up       <= 1'b0;
            r_next_due     <= '0;
            r_backoff      <= INIT_BACKOFF_RST;
            r_ovalid       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_was_up   <= n_was_up;
            r_next_due <= n_next_due;
            r_backoff  <= n_backoff;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INIT_BACKOFF: r_init_backoff <= i_cfg_data;
                    CFG_MAX_BACKOFF:  r_max_backoff  <= i_cfg_data;
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end
            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_s_tuser;
            r_now  <= i_s_tdata[TIME_W-1:0];
            r_up   <= i_s_tdata[TIME_W];
            r_rnd  <= i_s_tdata[TIME_W+1 +: RND_W];
        end
        r_att  <= n_att;
        r_came <= n_came;
        r_went <= n_went;
        if (w_oload) begin
            r_odata <= OUT_DATA_W'({r_backoff, r_next_due, r_went, r_came, r_att});
        end
    end

    rbj_jitter u_jitter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_jit_start),
        .i_backoff (r_backoff),
        .i_rnd     (r_rnd),
        .o_done    (w_jit_done),
        .o_r       (w_jit_r),
        .o_mod     (w_jit_mod)
    );

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    `RBJ_ASSERT_IMP(a_jit_done_in_wait, i_clk, i_rst_n, w_jit_done, r_state == S_JIT)
    `RBJ_ASSERT_NXT(a_backoff_capped, i_clk, i_rst_n, w_jit_done, r_backoff <= r_max_backoff)
    `RBJ_ASSERT_IMP(a_edges_exclusive, i_clk, i_rst_n, o_m_tvalid, !(o_m_tdata[1] && o_m_tdata[2]))
    `RBJ_ASSERT_IMP(a_no_attempt_on_up, i_clk, i_rst_n, o_m_tvalid, !(o_m_tdata[0] && o_m_tdata[1]))

endmodule

>>> tb/sv/reconnect_backoff_jitter_tb.sv
// Self-checking bench for the reconnect backoff scheduler: directed edge cases, then random
// link sessions with random handshake idling, checked against an in-bench schedule predictor.
// Depends on rbj_pkg and reconnect_backoff_jitter.
`timescale 1ns / 1ps

module reconnect_backoff_jitter_tb;

    import rbj_pkg::*;

    // Indexes past the register list; writes there must leave the block unchanged.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int REPORT_LIMIT = 10;
    localparam int TAIL_CYCLES  = 60;   // idle tail after the last result has come back

    // One result item, unpacked.
    typedef struct packed {
        logic              attempt;
        logic              came_up;
        logic              went_down;
        logic [TIME_W-1:0] next_due;
        logic [BO_W-1:0]   backoff;
    } t_plan;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // now_ms, link_up, random_word
    logic                  i_s_tuser;   // func
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // attempt_now, link_came_up, link_went_down, next_due_ms, backoff_now_ms, zero pad
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [BO_W-1:0]       i_cfg_data;

    reconnect_backoff_jitter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor copy of the configuration and the schedule state.
    logic [BO_W-1:0]   cfg_init;
    logic [BO_W-1:0]   cfg_max;
    logic              link_seen_up;
    logic [TIME_W-1:0] due_at;
    logic [BO_W-1:0]   cur_backoff;

    t_plan pending_plans[$];   // expected results, oldest first
    int    mismatches;
    bit    idle_en;            // random idling on both item channels
    logic [TIME_W-1:0] clock_ms;   // running millisecond time for the traffic generator

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: report FAIL if the run does not finish in time.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Schedule predictor: advance the state by one item, return the result.
    // ------------------------------------------------------------------
    function automatic t_plan predict_step(logic func, logic [TIME_W-1:0] now,
                                           logic up, logic [RND_W-1:0] rnd);
        t_plan             p;
        logic [TIME_W-1:0] wide_bo;
        logic [TIME_W-1:0] doubled;
        logic [TIME_W-1:0] r;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] jittered;
        p = '0;
        if (func == FUNC_BEGIN) begin
            // start request: attempt now, next one a plain backoff later
            p.attempt = 1'b1;
            due_at    = now + {{(TIME_W-BO_W){1'b0}}, cur_backoff};
        end else if (up) begin
            if (!link_seen_up) begin
                link_seen_up = 1'b1;
                cur_backoff  = cfg_init;
                p.came_up    = 1'b1;
            end
        end else begin
            if (link_seen_up) begin
                // drop seen: retry is due at once
                link_seen_up = 1'b0;
                p.went_down  = 1'b1;
                due_at       = now;
            end
            if (now >= due_at) begin
                wide_bo = {{(TIME_W-BO_W){1'b0}}, cur_backoff};
                doubled = wide_bo << 1;
                r       = wide_bo / 32'd5;
                if (r == '0) begin
                    jittered = wide_bo;
                end else begin
                    span     = (r << 1) + 32'd1;
                    jittered = wide_bo + ({1'b0, rnd} % span) - r;
                end
                p.attempt   = 1'b1;
                due_at      = now + jittered;
                cur_backoff = (doubled > {{(TIME_W-BO_W){1'b0}}, cfg_max}) ?
                              cfg_max : doubled[BO_W-1:0];
            end
        end
        p.next_due = due_at;
        p.backoff  = cur_backoff;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, and the check of every accepted item.
    // ------------------------------------------------------------------
    initial begin
        i_m_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_plan got;
        t_plan want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.attempt   = o_m_tdata[0];
            got.came_up   = o_m_tdata[1];
            got.went_down = o_m_tdata[2];
            got.next_due  = o_m_tdata[34:3];
            got.backoff   = o_m_tdata[54:35];
            if (pending_plans.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result att=%0b up=%0b down=%0b due=%0d bo=%0d",
                             $time, got.attempt, got.came_up, got.went_down,
                             got.next_due, got.backoff);
            end else begin
                want = pending_plans.pop_front();
                if (got.attempt !== want.attempt || got.came_up !== want.came_up ||
                    got.went_down !== want.went_down || got.next_due !== want.next_due ||
                    got.backoff !== want.backoff) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: expected att=%0b up=%0b down=%0b due=%0d bo=%0d",
                                 $time, want.attempt, want.came_up, want.went_down,
                                 want.next_due, want.backoff);
                        $display("%0t: actual   att=%0b up=%0b down=%0b due=%0d bo=%0d",
                                 $time, got.attempt, got.came_up, got.went_down,
                                 got.next_due, got.backoff);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Send one item. Called at a falling edge; returns at the falling edge after the
    // handshake with tvalid still high, so back-to-back items never drop tvalid.
    task automatic send_item(logic func, logic [TIME_W-1:0] now, logic up,
                             logic [RND_W-1:0] rnd);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {rnd, up, now};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_plans.push_back(predict_step(func, now, up, rnd));
        @(negedge i_clk);
    endtask

    // Drop tvalid and hold until every expected result has come back.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_plans.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write one register; leaves cfg valid high for a following write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BO_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_INIT_BACKOFF)
            cfg_init = value;
        else if (idx == CFG_MAX_BACKOFF)
            cfg_max = value;
        @(negedge i_clk);
    endtask

    // Reprogram both registers with the block idle.
    task automatic configure(logic [BO_W-1:0] init_ms, logic [BO_W-1:0] max_ms);
        drain_results();
        write_reg(CFG_INIT_BACKOFF, init_ms);
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, BO_W'($urandom));
        write_reg(CFG_MAX_BACKOFF, max_ms);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Start requests from reset state; link and random word are ignored, time wraps.
    task automatic test_start_request();
        send_item(FUNC_BEGIN, 32'h0000_0000, 1'b0, 31'h0000_0000);
        send_item(FUNC_BEGIN, 32'hFFFF_FFFF, 1'b1, 31'h7FFF_FFFF);
    endtask

    // Rising edge, steady up, falling edge with immediate retry, not-due and due ticks.
    task automatic test_link_edges();
        send_item(FUNC_TICK, 32'd100, 1'b1, 31'h0000_0000);
        send_item(FUNC_TICK, 32'd150, 1'b1, 31'h7FFF_FFFF);
        send_item(FUNC_TICK, 32'd200, 1'b0, 31'h0000_0000);   // lowest jitter
        send_item(FUNC_TICK, 32'd500, 1'b0, 31'h5555_5555);   // not yet due
        send_item(FUNC_TICK, due_at, 1'b0, 31'h7FFF_FFFF);    // due, largest random word
        send_item(FUNC_BEGIN, 32'd5000, 1'b1, 31'h2AAA_AAAA); // start while link down
    endtask

    // Saturation, zero backoff, backoff above the maximum, no-jitter range, time wrap.
    task automatic test_backoff_limits();
        configure(20'd600000, 20'd1000000);
        send_item(FUNC_TICK, 32'd10, 1'b1, 31'h0);
        send_item(FUNC_TICK, 32'd20, 1'b0, 31'h1234_5678);    // doubles into the ceiling
        send_item(FUNC_TICK, due_at, 1'b0, 31'h0765_4321);    // stays at the ceiling

        configure(20'd0, 20'd30000);
        send_item(FUNC_TICK, 32'd30, 1'b1, 31'h0);
        send_item(FUNC_TICK, 32'd40, 1'b0, 31'h7FFF_FFFF);    // zero stays zero
        send_item(FUNC_TICK, 32'd40, 1'b0, 31'h0);

        configure(20'hFFFFF, 20'd1);
        send_item(FUNC_TICK, 32'd50, 1'b1, 31'h0);
        send_item(FUNC_TICK, 32'd60, 1'b0, 31'h7FFF_FFFF);    // above the max, drops to it
        send_item(FUNC_TICK, due_at, 1'b0, 31'h3);

        configure(20'd4, 20'hFFFFF);
        send_item(FUNC_TICK, 32'hFFFF_FFF0, 1'b1, 31'h0);
        send_item(FUNC_TICK, 32'hFFFF_FFFE, 1'b0, 31'h7FFF_FFFF); // no jitter, due wraps
        send_item(FUNC_TICK, 32'hFFFF_FFFF, 1'b0, 31'h1);     // due by plain compare
    endtask

    // Random link sessions with random content, plus some noise items.
    task automatic run_traffic(int n_items, bit allow_reconfig);
        logic link;
        logic func;
        logic [TIME_W-1:0] now;
        logic up;
        link = 1'b0;
        for (int i = 0; i < n_items; i++) begin
            if (allow_reconfig && i % 80 == 79) begin
                case ($urandom_range(0, 5))
                    0: configure(20'd1, 20'd1000000);
                    1: configure(20'd1000000, 20'd1);
                    2: configure(BO_W'($urandom), BO_W'($urandom));
                    default: configure(BO_W'($urandom_range(1, 3000)),
                                       BO_W'($urandom_range(1, 60000)));
                endcase
            end else if (allow_reconfig && i % 80 == 40) begin
                drain_results();   // let every result come back before going on
            end
            if ($urandom_range(0, 5) == 0)
                link = ~link;
            if ($urandom_range(0, 9) == 0) begin
                // noise: anything the fields allow
                func = $urandom_range(0, 1) ? FUNC_BEGIN : FUNC_TICK;
                now  = $urandom;
                up   = 1'($urandom_range(0, 1));
            end else begin
                func = ($urandom_range(0, 9) == 0) ? FUNC_BEGIN : FUNC_TICK;
                up   = link;
                if (!link && $urandom_range(0, 1))
                    clock_ms = due_at + $urandom_range(0, 20);
                else
                    clock_ms = clock_ms + $urandom_range(0, 300);
                now = clock_ms;
            end
            send_item(func, now, up, RND_W'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        configure(20'd1000, 20'd30000);
        clock_ms = $urandom;
        run_traffic(480, 1'b1);
    endtask

    // Last stretch: no idling on either side, items back to back.
    task automatic test_steady_stream();
        configure(BO_W'($urandom_range(5, 2000)), BO_W'($urandom_range(1000, 40000)));
        idle_en = 1'b0;
        run_traffic(120, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = FUNC_TICK;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_INIT_BACKOFF;
        i_cfg_data  = '0;
        idle_en     = 1'b1;
        mismatches  = 0;
        clock_ms    = '0;

        cfg_init     = INIT_BACKOFF_RST;
        cfg_max      = MAX_BACKOFF_RST;
        link_seen_up = 1'b0;
        due_at       = '0;
        cur_backoff  = INIT_BACKOFF_RST;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_start_request();
        test_link_edges();
        test_backoff_limits();
        test_random_traffic();
        test_steady_stream();

        i_s_tvalid <= 1'b0;
        while (pending_plans.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rbj_pkg.sv
rtl/rbj_jitter.sv
rtl/reconnect_backoff_jitter.sv
tb/sv/reconnect_backoff_jitter_tb.sv
